@@ rtl/ps2md_pkg.sv @@
// Shared types and constants for the PS/2 mouse packet decoder.
package ps2md_pkg;

  localparam int KIND_W     = 2;
  localparam int BYTE_W     = 8;
  localparam int OUT_POS_W  = 12;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLICK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HOME  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd768;
  localparam int RESET_X = 512;
  localparam int RESET_Y = 384;

  localparam logic [BYTE_W-1:0] HDR_LEFT  = 8'h01;
  localparam logic [BYTE_W-1:0] HDR_RIGHT = 8'h02;
  localparam logic [BYTE_W-1:0] HDR_SYNC  = 8'h08;
  localparam logic [BYTE_W-1:0] HDR_XSIGN = 8'h10;
  localparam logic [BYTE_W-1:0] HDR_YSIGN = 8'h20;
  localparam logic [BYTE_W-1:0] HDR_OVF   = 8'hC0;

  localparam int DELTA_W = 10;
  typedef logic signed [DELTA_W-1:0] delta_t;

endpackage

@@ rtl/ps2md_if.sv @@
// Valid/ready channel interfaces for decoder events and results.
interface ps2md_in_if
  import ps2md_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              from_aux;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, kind, from_aux, data_byte, input ready);
  modport sink   (input valid, kind, from_aux, data_byte, output ready);
endinterface

interface ps2md_out_if
  import ps2md_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [OUT_POS_W-1:0] cursor_x;
  logic [OUT_POS_W-1:0] cursor_y;
  logic                 left_down;
  logic                 right_down;
  logic                 click_taken;
  logic                 packet_done;
  logic                 overflow_dropped;
  logic                 byte_ignored;

  modport source (output valid, cursor_x, cursor_y, left_down, right_down, click_taken,
                  packet_done, overflow_dropped, byte_ignored, input ready);
  modport sink   (input valid, cursor_x, cursor_y, left_down, right_down, click_taken,
                  packet_done, overflow_dropped, byte_ignored, output ready);
endinterface

@@ rtl/ps2md_move.sv @@
// Adds a signed delta to a cursor coordinate and clamps it to [0, size-1].
module ps2md_move
  import ps2md_pkg::*;
#(
  parameter int PW = 12,
  parameter int EW = 13
) (
  input  logic [PW-1:0] pos,
  input  delta_t        delta,
  input  logic [EW-1:0] size,
  output logic [PW-1:0] pos_new
);

  localparam int CW = ((PW > EW) ? PW : EW) + 2;

  logic signed [CW-1:0] sum;
  logic signed [CW-1:0] size_s;

  assign sum    = $signed(CW'(pos)) + CW'(delta);
  assign size_s = $signed(CW'(size));

  always_comb begin
    if (sum < 0) begin
      pos_new = '0;
    end else if (sum >= size_s) begin
      pos_new = PW'(size - EW'(1));
    end else begin
      pos_new = PW'(sum);
    end
  end

endmodule

@@ rtl/ps2_mouse_packet_decoder.sv @@
// Top level of the PS/2 mouse three-byte packet decoder.
//
//   channel  | direction | payload
//   in_ch    | sink      | kind, from_aux, data_byte
//   out_ch   | source    | cursor_x, cursor_y, buttons, click and packet flags
//   cfg_*    | write     | screen_width (index 0), screen_height (index 1)
//
// One beat is accepted every cycle while in_ch.ready is high; its result is registered.
// The input register and the result register are the two stages of the path.
// A stalled result holds the result register, and the input register then holds the
// next beat; in_ch.ready drops only when both are full.
// Reset is synchronous; there is no clearing pass.
module ps2_mouse_packet_decoder
  import ps2md_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  ps2md_in_if.sink              in_ch,
  ps2md_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PW = (COORD_BITS > OUT_POS_W) ? COORD_BITS : OUT_POS_W;
  localparam int EW = (COORD_BITS + 1 > CFG_DATA_W) ? COORD_BITS + 1 : CFG_DATA_W;
  localparam logic [EW-1:0] SIZE_LIM   = EW'(64'd1 << COORD_BITS);
  localparam logic [PW-1:0] COORD_MASK = PW'((64'd1 << COORD_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_XDELTA,
    PH_YDELTA
  } phase_t;

  logic [CFG_DATA_W-1:0] width_r, height_r;

  logic              s1_valid_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic              s1_aux_r;
  logic [BYTE_W-1:0] s1_byte_r;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] hdr_r, hdr_nxt;
  logic [BYTE_W-1:0] xb_r, xb_nxt;
  logic [PW-1:0]     ptr_x_r, ptr_x_nxt;
  logic [PW-1:0]     ptr_y_r, ptr_y_nxt;
  logic              left_r, left_nxt;
  logic              right_r, right_nxt;
  logic              latch_r, latch_nxt;

  logic taken, done, ovf, ign;

  logic                 out_valid_r;
  logic [OUT_POS_W-1:0] out_x_r, out_y_r;
  logic                 out_left_r, out_right_r;
  logic                 out_taken_r, out_done_r, out_ovf_r, out_ign_r;

  logic          advance;
  logic [EW-1:0] eff_w, eff_h;
  delta_t        dx, ndy;
  logic [PW-1:0] move_x, move_y;
  logic [PW-1:0] masked_x, masked_y;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (EW'(width_r) > SIZE_LIM) begin
      eff_w = SIZE_LIM;
    end else begin
      eff_w = EW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = EW'(1);
    end else if (EW'(height_r) > SIZE_LIM) begin
      eff_h = SIZE_LIM;
    end else begin
      eff_h = EW'(height_r);
    end
  end

  assign dx  = $signed({{(DELTA_W - BYTE_W){|(hdr_r & HDR_XSIGN)}}, xb_r});
  assign ndy = -$signed({{(DELTA_W - BYTE_W){|(hdr_r & HDR_YSIGN)}}, s1_byte_r});

  ps2md_move #(.PW(PW), .EW(EW)) u_move_x (
    .pos     (ptr_x_r),
    .delta   (dx),
    .size    (eff_w),
    .pos_new (move_x)
  );

  ps2md_move #(.PW(PW), .EW(EW)) u_move_y (
    .pos     (ptr_y_r),
    .delta   (ndy),
    .size    (eff_h),
    .pos_new (move_y)
  );

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    xb_nxt    = xb_r;
    ptr_x_nxt = ptr_x_r;
    ptr_y_nxt = ptr_y_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    latch_nxt = latch_r;
    taken     = 1'b0;
    done      = 1'b0;
    ovf       = 1'b0;
    ign       = 1'b0;
    unique case (s1_kind_r)
      KIND_BYTE: begin
        if (!s1_aux_r) begin
          ign = 1'b1;
        end else begin
          unique case (phase_r)
            PH_HEADER: begin
              if ((s1_byte_r & HDR_SYNC) == '0) begin
                ign = 1'b1;
              end else begin
                hdr_nxt   = s1_byte_r;
                phase_nxt = PH_XDELTA;
              end
            end
            PH_XDELTA: begin
              xb_nxt    = s1_byte_r;
              phase_nxt = PH_YDELTA;
            end
            default: begin
              phase_nxt = PH_HEADER;
              done      = 1'b1;
              left_nxt  = |(hdr_r & HDR_LEFT);
              right_nxt = |(hdr_r & HDR_RIGHT);
              if (left_nxt && !left_r) begin
                latch_nxt = 1'b1;
              end
              if ((hdr_r & HDR_OVF) != '0) begin
                ovf = 1'b1;
              end else begin
                ptr_x_nxt = move_x;
                ptr_y_nxt = move_y;
              end
            end
          endcase
        end
      end
      KIND_CLICK: begin
        taken     = latch_r;
        latch_nxt = 1'b0;
      end
      KIND_HOME: begin
        ptr_x_nxt = PW'(eff_w >> 1);
        ptr_y_nxt = PW'(eff_h >> 1);
        phase_nxt = PH_HEADER;
      end
      default: begin
      end
    endcase
  end

  assign masked_x = ptr_x_nxt & COORD_MASK;
  assign masked_y = ptr_y_nxt & COORD_MASK;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_WIDTH;
      height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_kind_r <= in_ch.kind;
      s1_aux_r  <= in_ch.from_aux;
      s1_byte_r <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      hdr_r   <= '0;
      xb_r    <= '0;
      ptr_x_r <= PW'(RESET_X);
      ptr_y_r <= PW'(RESET_Y);
      left_r  <= 1'b0;
      right_r <= 1'b0;
      latch_r <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      xb_r    <= xb_nxt;
      ptr_x_r <= ptr_x_nxt;
      ptr_y_r <= ptr_y_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      latch_r <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_x_r     <= masked_x[OUT_POS_W-1:0];
      out_y_r     <= masked_y[OUT_POS_W-1:0];
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_taken_r <= taken;
      out_done_r  <= done;
      out_ovf_r   <= ovf;
      out_ign_r   <= ign;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.cursor_x         = out_x_r;
  assign out_ch.cursor_y         = out_y_r;
  assign out_ch.left_down        = out_left_r;
  assign out_ch.right_down       = out_right_r;
  assign out_ch.click_taken      = out_taken_r;
  assign out_ch.packet_done      = out_done_r;
  assign out_ch.overflow_dropped = out_ovf_r;
  assign out_ch.byte_ignored     = out_ign_r;

endmodule

@@ rtl/ps2md_checker.sv @@
// Port-level checks for the PS/2 mouse packet decoder and their binding.
module ps2md_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic click_taken,
  input logic packet_done,
  input logic overflow_dropped,
  input logic byte_ignored
);

  // A result beat that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // The input side only stalls when a finished result is waiting.
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // A new result on an empty output comes from a beat accepted into the input register.
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching input beat");

  // Each result reports at most one event, and an overflow only on a finished packet.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({click_taken, packet_done, byte_ignored}) <= 1)
                  && (!overflow_dropped || packet_done))
    else $error("inconsistent result flags");

endmodule

bind ps2_mouse_packet_decoder ps2md_checker u_ps2md_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .click_taken      (out_ch.click_taken),
  .packet_done      (out_ch.packet_done),
  .overflow_dropped (out_ch.overflow_dropped),
  .byte_ignored     (out_ch.byte_ignored)
);
